>>> rtl/pidc_pkg.sv
// Shared types and constants for the PID controller with dead zone and clamps.
// Holds data widths, register indexes, reset values and the configuration struct.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    // Data path widths (signed Q16.16 by default).
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int DB_W   = DATA_W - 1;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int ACC_W  = TERM_W + 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_UPPER   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_LOWER   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_UPPER = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LOWER = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND    = 3'd7;

    localparam logic [DATA_W-1:0] RST_GAIN_P      = 32'sd5243;
    localparam logic [DATA_W-1:0] RST_GAIN_I      = 32'sd1966;
    localparam logic [DATA_W-1:0] RST_GAIN_D      = 32'sd0;
    localparam logic [DATA_W-1:0] RST_INT_UPPER   = 32'sd32768000;
    localparam logic [DATA_W-1:0] RST_INT_LOWER   = -32'sd32768000;
    localparam logic [DATA_W-1:0] RST_DRIVE_UPPER = 32'sd524288;
    localparam logic [DATA_W-1:0] RST_DRIVE_LOWER = -32'sd524288;
    localparam logic [DB_W-1:0]   RST_DEADBAND    = 31'd0;

    // Stream widths.
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = DATA_W;

    // Capacity of the whole block: front register, queue and four back stages.
    localparam int QUEUE_DEPTH = 2;
    localparam int CAPACITY    = 1 + QUEUE_DEPTH + 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] int_upper;
        logic signed [DATA_W-1:0] int_lower;
        logic signed [DATA_W-1:0] drive_upper;
        logic signed [DATA_W-1:0] drive_lower;
        logic        [DB_W-1:0]   deadband;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/pidc_front.sv
// Front end: accepts a sample beat, forms the saturated error and applies the dead zone.
// The classified error is held in one register until the queue takes it.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [pidc_pkg::DB_W-1:0]       i_deadband,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [pidc_pkg::DATA_W-1:0]     i_setpoint,
    input  wire logic [pidc_pkg::DATA_W-1:0]     i_measured,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [pidc_pkg::DATA_W-1:0]          o_err
);

    logic                            r_valid;
    logic [pidc_pkg::DATA_W-1:0]     r_err;
    logic [pidc_pkg::DATA_W:0]       w_diff;
    logic [pidc_pkg::DATA_W-1:0]     w_sat;
    logic [pidc_pkg::DATA_W-1:0]     w_mag;
    logic [pidc_pkg::DATA_W-1:0]     n_err;

    always_comb begin
        w_diff = {i_setpoint[pidc_pkg::DATA_W-1], i_setpoint}
               - {i_measured[pidc_pkg::DATA_W-1], i_measured};
        // The two top bits disagree only when the difference left the signed range.
        if (w_diff[pidc_pkg::DATA_W] != w_diff[pidc_pkg::DATA_W-1]) begin
            w_sat = w_diff[pidc_pkg::DATA_W]
                  ? {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}}
                  : {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
        end else begin
            w_sat = w_diff[pidc_pkg::DATA_W-1:0];
        end
        // The magnitude of the most negative value reads correctly as unsigned.
        w_mag = w_sat[pidc_pkg::DATA_W-1] ? (~w_sat + 1'b1) : w_sat;
        n_err = (w_mag < {1'b0, i_deadband}) ? '0 : w_sat;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_err   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidc_queue.sv
// Two-entry queue between the front end and the back end.
// Takes a push and a pop in the same cycle unless full, so it passes one beat per cycle while the back end takes them.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [pidc_pkg::DATA_W-1:0]     i_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [pidc_pkg::DATA_W-1:0]          o_data
);

    localparam int PTR_W = $clog2(pidc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pidc_pkg::QUEUE_DEPTH + 1);

    logic [pidc_pkg::DATA_W-1:0] r_mem [pidc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]            r_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr;
    logic [CNT_W-1:0]            r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_ready = (r_count != CNT_W'(pidc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidc_back.sv
// Back end: integrator with clamp, derivative, three gain products, sum and drive clamp.
// Four stages that advance together whenever the output register can move.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pidc_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [pidc_pkg::DATA_W-1:0]     i_err,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [pidc_pkg::DATA_W-1:0]          o_drive
);

    localparam int DW = pidc_pkg::DATA_W;

    logic w_en;
    logic w_take;

    // Loop state of the controller.
    logic signed [DW-1:0]                  r_sum;
    logic signed [DW-1:0]                  r_prev;

    // Stage 1: integrator and derivative.
    logic                                  r1_valid;
    logic signed [DW-1:0]                  r1_err;
    logic signed [DW-1:0]                  r1_sum;
    logic signed [pidc_pkg::DIFF_W-1:0]    r1_diff;

    // Stage 2: scaled products.
    logic                                  r2_valid;
    logic signed [pidc_pkg::TERM_W-1:0]    r2_term_p;
    logic signed [pidc_pkg::TERM_W-1:0]    r2_term_i;
    logic signed [pidc_pkg::TERM_W-1:0]    r2_term_d;

    // Stage 3: sum of terms.
    logic                                  r3_valid;
    logic signed [pidc_pkg::ACC_W-1:0]     r3_acc;

    // Stage 4: clamped output register.
    logic                                  r_out_valid;
    logic [DW-1:0]                         r_out_drive;

    logic signed [DW:0]                    w_sum_wide;
    logic signed [DW-1:0]                  n_sum;
    logic signed [pidc_pkg::DIFF_W-1:0]    n_diff;
    logic signed [pidc_pkg::PROD_W-1:0]    w_prod_p;
    logic signed [pidc_pkg::PROD_W-1:0]    w_prod_i;
    logic signed [pidc_pkg::PROD_W:0]      w_prod_d;
    logic signed [pidc_pkg::ACC_W-1:0]     n_acc;
    logic signed [pidc_pkg::ACC_W-1:0]     w_drive_hi;
    logic signed [pidc_pkg::ACC_W-1:0]     w_drive_lo;
    logic [DW-1:0]                         n_drive;

    assign w_en    = !r_out_valid || i_ready;
    assign w_take  = w_en && i_valid;
    assign o_ready = w_en;
    assign o_valid = r_out_valid;
    assign o_drive = r_out_drive;

    always_comb begin
        w_sum_wide = {r_sum[DW-1], r_sum} + {i_err[DW-1], i_err};
        // Upper bound is tested first; with crossed bounds a sum above it takes the upper one, any other sum the lower.
        if (w_sum_wide > $signed({i_cfg.int_upper[DW-1], i_cfg.int_upper})) begin
            n_sum = i_cfg.int_upper;
        end else if (w_sum_wide < $signed({i_cfg.int_lower[DW-1], i_cfg.int_lower})) begin
            n_sum = i_cfg.int_lower;
        end else begin
            n_sum = w_sum_wide[DW-1:0];
        end
        n_diff = {i_err[DW-1], i_err} - {r_prev[DW-1], r_prev};
    end

    always_comb begin
        w_prod_p = i_cfg.gain_p * r1_err;
        w_prod_i = i_cfg.gain_i * r1_sum;
        // The derivative product never needs its top bit; the low word is exact.
        w_prod_d = i_cfg.gain_d * r1_diff;
    end

    always_comb begin
        n_acc = pidc_pkg::ACC_W'(r2_term_p) + pidc_pkg::ACC_W'(r2_term_i)
              + pidc_pkg::ACC_W'(r2_term_d);
        w_drive_hi = pidc_pkg::ACC_W'(i_cfg.drive_upper);
        w_drive_lo = pidc_pkg::ACC_W'(i_cfg.drive_lower);
        if (r3_acc > w_drive_hi) begin
            n_drive = i_cfg.drive_upper;
        end else if (r3_acc < w_drive_lo) begin
            n_drive = i_cfg.drive_lower;
        end else begin
            n_drive = r3_acc[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_prev      <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_sum  <= n_sum;
                r_prev <= i_err;
            end
            if (w_en) begin
                r1_valid    <= i_valid;
                r2_valid    <= r1_valid;
                r3_valid    <= r2_valid;
                r_out_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_err      <= i_err;
            r1_sum      <= n_sum;
            r1_diff     <= n_diff;
            r2_term_p   <= w_prod_p[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
            r2_term_i   <= w_prod_i[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
            r2_term_d   <= w_prod_d[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
            r3_acc      <= n_acc;
            r_out_drive <= n_drive;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pid_controller_deadzone_clamp.sv
// PID controller step with dead zone, integral clamp and drive clamp, Q16.16 data.
// Throughput: one sample beat per cycle while m_axis takes its beats; the integrator's add-and-clamp loop
// runs from r_sum back to r_sum through logic alone. A sample passes front, queue and back stages 1 to 4 in turn.
// Up to seven beats can be in flight; a stall on m_axis freezes the back end, and
// s_axis_tready falls once the queue and the front register are both full.
// Reset (synchronous, active low) empties the block, zeroes the integral and last error,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_deadzone_clamp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pidc_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire logic [pidc_pkg::DATA_W-1:0]           i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [31:0] setpoint, [63:32] measured
    input  wire logic [pidc_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] drive
    output logic [pidc_pkg::M_TDATA_W-1:0]             m_axis_tdata
);

    pidc_pkg::t_cfg                  r_cfg;
    logic                            w_fr_valid;
    logic                            w_fr_ready;
    logic [pidc_pkg::DATA_W-1:0]     w_fr_err;
    logic                            w_q_valid;
    logic                            w_q_ready;
    logic [pidc_pkg::DATA_W-1:0]     w_q_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= pidc_pkg::RST_GAIN_P;
            r_cfg.gain_i      <= pidc_pkg::RST_GAIN_I;
            r_cfg.gain_d      <= pidc_pkg::RST_GAIN_D;
            r_cfg.int_upper   <= pidc_pkg::RST_INT_UPPER;
            r_cfg.int_lower   <= pidc_pkg::RST_INT_LOWER;
            r_cfg.drive_upper <= pidc_pkg::RST_DRIVE_UPPER;
            r_cfg.drive_lower <= pidc_pkg::RST_DRIVE_LOWER;
            r_cfg.deadband    <= pidc_pkg::RST_DEADBAND;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pidc_pkg::REG_GAIN_P:      r_cfg.gain_p      <= i_cfg_data;
                pidc_pkg::REG_GAIN_I:      r_cfg.gain_i      <= i_cfg_data;
                pidc_pkg::REG_GAIN_D:      r_cfg.gain_d      <= i_cfg_data;
                pidc_pkg::REG_INT_UPPER:   r_cfg.int_upper   <= i_cfg_data;
                pidc_pkg::REG_INT_LOWER:   r_cfg.int_lower   <= i_cfg_data;
                pidc_pkg::REG_DRIVE_UPPER: r_cfg.drive_upper <= i_cfg_data;
                pidc_pkg::REG_DRIVE_LOWER: r_cfg.drive_lower <= i_cfg_data;
                pidc_pkg::REG_DEADBAND: begin
                    r_cfg.deadband <= i_cfg_data[pidc_pkg::DB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pidc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_deadband (r_cfg.deadband),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_setpoint (s_axis_tdata[pidc_pkg::DATA_W-1:0]),
        .i_measured (s_axis_tdata[pidc_pkg::S_TDATA_W-1:pidc_pkg::DATA_W]),
        .o_valid    (w_fr_valid),
        .i_ready    (w_fr_ready),
        .o_err      (w_fr_err)
    );

    pidc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_data  (w_fr_err),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_err)
    );

    pidc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_err   (w_q_err),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_drive (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/pidc_checker.sv
// Port-level checks for the PID controller, attached to the top level by bind.
// Tracks beats in flight from the stream handshakes; depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    input  wire logic                                  s_axis_tready,
    input  wire logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic [pidc_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    localparam int CNT_W = $clog2(pidc_pkg::CAPACITY + 1) + 1;

    logic             w_in_beat;
    logic             w_out_beat;
    logic [CNT_W-1:0] r_inflight;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (w_out_beat && !w_in_beat) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A drive beat only appears for a sample beat that is still owed one.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != '0)
        else $error("output beat without a pending sample");

    // The block never holds more beats than its storage allows.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(pidc_pkg::CAPACITY))
        else $error("more beats in flight than the block can hold");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind pid_controller_deadzone_clamp pidc_checker u_pidc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
